@@ rtl/pd_pkg.sv @@
// percent decoder shared types, character constants and hex digit helper
`timescale 1ns / 1ps

package pd_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // one classified input word: up to three bytes to emit
  typedef struct packed {
    logic       last;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } pd_cmd_t;

  // hex digit value, bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

@@ rtl/pd_front.sv @@
// percent decoder front end: escape tracking and command building
`timescale 1ns / 1ps

module pd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  logic           cfg_we,
  input  logic           cfg_plus_to_space,
  output logic           cmd_we,
  output pd_pkg::pd_cmd_t cmd
);
  import pd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       plus_r, plus_nxt;

  logic [4:0] in_v;
  logic [4:0] held_v;
  logic       p_valid;
  logic [7:0] p_byte;
  phase_t     p_phase;

  always_comb begin
    in_v   = hex_val(in_byte);
    held_v = hex_val(held_r);

    // byte handled with no escape pending
    if (in_byte == PCT_CHAR) begin
      p_valid = in_last;
      p_byte  = PCT_CHAR;
      p_phase = in_last ? PH_IDLE : PH_PCT;
    end else begin
      p_valid = 1'b1;
      p_byte  = (in_byte == PLUS_CHAR && plus_r) ? SPACE_CHAR : in_byte;
      p_phase = PH_IDLE;
    end

    held_nxt  = held_r;
    cmd.last  = in_last;
    cmd.cnt   = 2'd0;
    cmd.b0    = p_byte;
    cmd.b1    = p_byte;
    cmd.b2    = p_byte;
    phase_nxt = p_phase;

    case (phase_r)
      PH_PCT: begin
        if (!in_v[4]) begin
          if (in_last) begin
            cmd.cnt   = 2'd2;
            cmd.b0    = PCT_CHAR;
            cmd.b1    = in_byte;
            phase_nxt = PH_IDLE;
          end else begin
            held_nxt  = in_byte;
            phase_nxt = PH_DIG;
          end
        end else begin
          cmd.cnt = p_valid ? 2'd2 : 2'd1;
          cmd.b0  = PCT_CHAR;
        end
      end
      PH_DIG: begin
        if (!in_v[4]) begin
          cmd.cnt   = 2'd1;
          cmd.b0    = {held_v[3:0], in_v[3:0]};
          phase_nxt = PH_IDLE;
        end else begin
          cmd.cnt = p_valid ? 2'd3 : 2'd2;
          cmd.b0  = PCT_CHAR;
          cmd.b1  = held_r;
        end
      end
      default: begin
        cmd.cnt = p_valid ? 2'd1 : 2'd0;
      end
    endcase

    cmd_we   = accept && (cmd.cnt != 2'd0);
    plus_nxt = cfg_we ? cfg_plus_to_space : plus_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
      plus_r  <= 1'b1;
    end else begin
      plus_r <= plus_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
      end
    end
  end

endmodule

@@ rtl/pd_cmd_fifo.sv @@
// percent decoder command queue between front and back end
`timescale 1ns / 1ps

module pd_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  pd_pkg::pd_cmd_t wr_data,
  input  logic            rd_en,
  output pd_pkg::pd_cmd_t rd_data,
  output logic            fifo_full,
  output logic            fifo_empty
);
  import pd_pkg::*;

  pd_cmd_t                mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [CMD_PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CMD_CNT_W-1:0]   count_r, count_nxt;
  logic                   do_wr, do_rd;

  always_comb begin
    fifo_full  = (count_r == CMD_CNT_W'(CMD_DEPTH));
    fifo_empty = (count_r == '0);
    do_wr      = wr_en && !fifo_full;
    do_rd      = rd_en && !fifo_empty;
    rd_data    = mem_r[rptr_r];
    wptr_nxt   = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt   = do_rd ? rptr_r + 1'b1 : rptr_r;
    count_nxt  = count_r + CMD_CNT_W'(do_wr) - CMD_CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/pd_back.sv @@
// percent decoder back end: byte serializer and output register
`timescale 1ns / 1ps

module pd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  pd_pkg::pd_cmd_t cmd,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_string_end
);
  import pd_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       run_last_r, run_last_nxt;
  logic       end_r, end_nxt;
  logic       load;
  logic       tail;

  always_comb begin
    load = !valid_r || pop;
    tail = (idx_r == cmd.cnt - 2'd1);

    case (idx_r)
      2'd0:    byte_nxt = cmd.b0;
      2'd1:    byte_nxt = cmd.b1;
      default: byte_nxt = cmd.b2;
    endcase

    run_last_nxt = tail;
    end_nxt      = tail && cmd.last;
    cmd_pop      = load && !cmd_empty && tail;
    valid_nxt    = load ? !cmd_empty : valid_r;
    idx_nxt      = idx_r;
    if (load && !cmd_empty) begin
      idx_nxt = tail ? 2'd0 : idx_r + 2'd1;
    end

    empty          = !valid_r;
    out_byte       = byte_r;
    out_run_last   = run_last_r;
    out_string_end = end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !cmd_empty) begin
      byte_r     <= byte_nxt;
      run_last_r <= run_last_nxt;
      end_r      <= end_nxt;
    end
  end

endmodule

@@ rtl/percent_decoder.sv @@
// percent decoder top level: front end, command queue and back end
//
//   channel   ports                                    accepted when
//   input     push full in_byte in_last                push && !full
//   result    empty pop out_byte out_run_last
//             out_string_end                           pop && !empty
//   config    cfg_valid cfg_ready cfg_plus_to_space    cfg_valid && cfg_ready
//
// one input word per cycle while not full; results leave one byte per cycle from
// the back end serializer while pop is held, so a word that makes two or three
// bytes holds its queue entry until its last byte is loaded and a four entry
// command queue absorbs the difference; each result is queued, then registered
// in the back end; reset is synchronous and active low; plus mapping resets to on

`timescale 1ns / 1ps

module percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_plus_to_space
);
  import pd_pkg::*;

  pd_cmd_t wr_cmd;
  pd_cmd_t rd_cmd;
  logic    cmd_we;
  logic    cmd_pop;
  logic    cmd_empty;
  logic    accept;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  pd_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .in_byte           (in_byte),
    .in_last           (in_last),
    .cfg_we            (cfg_valid),
    .cfg_plus_to_space (cfg_plus_to_space),
    .cmd_we            (cmd_we),
    .cmd               (wr_cmd)
  );

  pd_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cmd_we),
    .wr_data    (wr_cmd),
    .rd_en      (cmd_pop),
    .rd_data    (rd_cmd),
    .fifo_full  (full),
    .fifo_empty (cmd_empty)
  );

  pd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (rd_cmd),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule

@@ rtl/pd_checker.sv @@
// percent decoder port checker and its bind
`timescale 1ns / 1ps

module pd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic [7:0] in_byte,
  input logic       in_last,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_string_end,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       cfg_plus_to_space
);

  // reset leaves both sides open and no word waiting
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queue not clear after reset");

  // a word not taken stays on the result ports
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_run_last)
                       && $stable(out_string_end))
    else $error("result word changed while stalled");

  // end of string always closes the run of its input word
  a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_string_end |-> out_run_last)
    else $error("string end without run last");

  // a full command queue implies a result word is waiting
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty)
    else $error("queue full with no result shown");

endmodule

bind percent_decoder pd_checker u_pd_checker (.*);
